/* rtl/assert_macros.svh */
// assertion macros for the rtl files, included by array_list_engine_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ALE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ALE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ale_pkg.sv */
// types, codes and sizes shared by the array list engine
package ale_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int WORD_W   = 32;

  typedef logic [2:0]        cmd_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [1:0]        status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam cmd_t CMD_READ   = 3'd0;
  localparam cmd_t CMD_WRITE  = 3'd1;
  localparam cmd_t CMD_APPEND = 3'd2;
  localparam cmd_t CMD_INSERT = 3'd3;
  localparam cmd_t CMD_DELETE = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // action broadcast along the row of cells
  typedef logic [1:0] act_t;
  localparam act_t ACT_NONE = 2'd0;
  localparam act_t ACT_SET  = 2'd1;
  localparam act_t ACT_INS  = 2'd2;
  localparam act_t ACT_DEL  = 2'd3;

  typedef struct packed {
    act_t  act;
    pos_t  pos;
    word_t word;
  } cell_ctl_t;

endpackage

/* rtl/ale_cmd_if.sv */
// command channel: valid, ready and one command beat
interface ale_cmd_if;
  import ale_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  pos_t  position;
  word_t word_in;

  modport source (output valid, output command, output position, output word_in,
                  input ready);
  modport sink (input valid, input command, input position, input word_in,
                output ready);
endinterface

/* rtl/ale_res_if.sv */
// result channel: valid, ready and one result beat
interface ale_res_if;
  import ale_pkg::*;

  logic    valid;
  logic    ready;
  word_t   word_out;
  cnt_t    count;
  status_t status;

  modport source (output valid, output word_out, output count, output status,
                  input ready);
  modport sink (input valid, input word_out, input count, input status,
                output ready);
endinterface

/* rtl/array_list_engine_top.sv */
// Array list engine: an ordered list of up to 64 signed 32-bit words held in a row of
// cells, one word per cell. For each of read, overwrite, append, insert and delete,
// a command beat is decoded against the entry count and broadcast to every cell,
// and insert or delete moves all later entries one place as the beat is taken, through
// the neighbour links. The result appears on the registered output the cycle after the
// command beat, and a new command is taken every cycle while results are drained.
// Out-of-range indices and append or insert on a full list leave the list unchanged
// and are reported in the status.
module array_list_engine_top (
  input logic     clk,
  input logic     rst,
  ale_cmd_if.sink cmd,
  ale_res_if.source res
);
  import ale_pkg::*;

`include "assert_macros.svh"

  cnt_t      count;
  cnt_t      count_next;
  cell_ctl_t ctl;
  act_t      act;
  pos_t      act_pos;
  status_t   st;
  word_t     rd_result;
  word_t     sel_word;
  logic      in_fire;
  logic      in_range;
  logic      full;
  logic      res_valid;

  word_t cell_word [CAPACITY];
  word_t cell_rd   [CAPACITY];

  assign cmd.ready = !res_valid || res.ready;
  assign in_fire   = cmd.valid && cmd.ready;
  assign in_range  = {1'b0, cmd.position} < count;
  assign full      = count == CNT_W'(CAPACITY);

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | cell_rd[i];
    end
  end

  always_comb begin
    act        = ACT_NONE;
    act_pos    = cmd.position;
    st         = ST_OK;
    rd_result  = '0;
    count_next = count;
    unique case (cmd.command)
      CMD_READ: begin
        if (in_range) rd_result = sel_word;
        else st = ST_RANGE;
      end
      CMD_WRITE: begin
        if (in_range) act = ACT_SET;
        else st = ST_RANGE;
      end
      CMD_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          act        = ACT_SET;
          act_pos    = count[POS_W-1:0];
          count_next = count + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if ({1'b0, cmd.position} > count) begin
          st = ST_RANGE;
        end else begin
          act        = ACT_INS;
          count_next = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (in_range) begin
          rd_result  = sel_word;
          act        = ACT_DEL;
          count_next = count - 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  assign ctl.act  = in_fire ? act : ACT_NONE;
  assign ctl.pos  = act_pos;
  assign ctl.word = cmd.word_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ale_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (POS_W'(i)),
      .below   ((i == 0) ? word_t'('0) : cell_word[(i == 0) ? 0 : i - 1]),
      .above   ((i == CAPACITY - 1) ? word_t'('0)
                                    : cell_word[(i == CAPACITY - 1) ? i : i + 1]),
      .rd_pos  (cmd.position),
      .word    (cell_word[i]),
      .rd_word (cell_rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res.word_out <= rd_result;
      res.count    <= count_next;
      res.status   <= st;
    end
  end

  assign res.valid = res_valid;

  `ALE_ASSERT_ALWAYS(a_reset_idle, rst |=> !res_valid, "result valid after reset")
  `ALE_ASSERT(a_count_cap, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `ALE_ASSERT(a_beat_gives_result, in_fire |=> res_valid, "command beat without result")
  `ALE_ASSERT(a_count_idle, !in_fire |=> $stable(count), "count moved without a command")
  `ALE_ASSERT(a_full_status, res_valid && res.status == ST_FULL |-> full, "full status too early")

endmodule

/* rtl/ale_cell.sv */
// one list entry: holds a word and takes it from itself, a neighbour or the input
module ale_cell (
  input  logic              clk,
  input  ale_pkg::cell_ctl_t ctl,
  input  ale_pkg::pos_t     idx,
  input  ale_pkg::word_t    below,
  input  ale_pkg::word_t    above,
  input  ale_pkg::pos_t     rd_pos,
  output ale_pkg::word_t    word,
  output ale_pkg::word_t    rd_word
);
  import ale_pkg::*;

  word_t word_next;

  always_comb begin
    word_next = word;
    unique case (ctl.act)
      ACT_SET: begin
        if (idx == ctl.pos) word_next = ctl.word;
      end
      ACT_INS: begin
        if (idx > ctl.pos) word_next = below;
        else if (idx == ctl.pos) word_next = ctl.word;
      end
      ACT_DEL: begin
        if (idx >= ctl.pos) word_next = above;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // and-or read bus: only the addressed cell drives non-zero
  assign rd_word = (idx == rd_pos) ? word : '0;

endmodule
